/* rtl/mbc_pkg.sv */
`default_nettype none

package mbc_pkg;

    localparam int unsigned KeyWords  = 8;
    localparam int unsigned Rounds    = 32;
    localparam int unsigned HalfWidth = 32;
    localparam int unsigned KeyIdxW   = $clog2(KeyWords);
    localparam int unsigned RoundIdxW = $clog2(Rounds);
    localparam int unsigned AddrWidth = 4;

    // The first 24 encryption rounds cycle through the key words forward.
    localparam logic [RoundIdxW-1:0] FwdRounds = RoundIdxW'(24);
    localparam logic [RoundIdxW-1:0] LastRound = RoundIdxW'(Rounds - 1);
    localparam int unsigned RotLeft = 11;

    // Direction codes carried in the user sideband.
    localparam logic ActEncrypt = 1'b0;
    localparam logic ActDecrypt = 1'b1;

    typedef logic [HalfWidth-1:0] word_t;
    typedef word_t [KeyWords-1:0] key_bank_t;

    // Block state that travels down the round pipeline.
    typedef struct packed {
        logic  decrypt;
        word_t hi;
        word_t lo;
    } mbc_state_t;

    // Status from the output stage back to the pipeline control.
    typedef struct packed {
        logic skid_full;
    } mbc_out_status_t;

    // Standard substitution boxes, one row per nibble position.
    localparam logic [3:0] SBOX [KeyWords][16] = '{
        '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
          4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
        '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
          4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
        '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
          4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
        '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
          4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
        '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
          4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
        '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
          4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
        '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
          4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
        '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
          4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
    };

    // Substitute all eight nibbles of a word.
    function automatic word_t sbox_word(input word_t s);
        word_t sub;
        sub = '0;
        for (int n = 0; n < KeyWords; n++) begin
            sub[4*n +: 4] = SBOX[n][s[4*n +: 4]];
        end
        return sub;
    endfunction

    // Feistel function: key add, substitution, rotate left.
    function automatic word_t round_fn(input word_t rk, input word_t half);
        word_t s;
        word_t sub;
        s   = rk + half;
        sub = sbox_word(s);
        return {sub[HalfWidth-RotLeft-1:0], sub[HalfWidth-1:HalfWidth-RotLeft]};
    endfunction

    // Key word used in a given round; decryption walks the schedule backward.
    function automatic logic [KeyIdxW-1:0] key_index(
        input logic [RoundIdxW-1:0] round_idx,
        input logic                 decrypt
    );
        logic [RoundIdxW-1:0] e;
        e = decrypt ? (LastRound - round_idx) : round_idx;
        return (e < FwdRounds) ? e[KeyIdxW-1:0] : ~e[KeyIdxW-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/mbc_keys.sv */
`default_nettype none

module mbc_keys (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [mbc_pkg::AddrWidth-1:0] cfg_addr,
    input  wire mbc_pkg::word_t               cfg_wdata,
    output mbc_pkg::key_bank_t                keys
);

    mbc_pkg::key_bank_t keys_reg;
    mbc_pkg::key_bank_t keys_next;

    // Writes to an index past the last key word are dropped.
    always_comb begin
        keys_next = keys_reg;
        if (cfg_wr_en && (cfg_addr < mbc_pkg::AddrWidth'(mbc_pkg::KeyWords))) begin
            keys_next[cfg_addr[mbc_pkg::KeyIdxW-1:0]] = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keys_reg <= '0;
        end else begin
            keys_reg <= keys_next;
        end
    end

    assign keys = keys_reg;

endmodule

`default_nettype wire

/* rtl/mbc_round.sv */
`default_nettype none

module mbc_round (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic [mbc_pkg::RoundIdxW-1:0] round_idx,
    input  wire mbc_pkg::key_bank_t            keys,
    input  wire logic                          in_valid,
    input  wire mbc_pkg::mbc_state_t           in_state,
    output logic                               out_valid,
    output mbc_pkg::mbc_state_t                out_state
);

    logic                valid_reg;
    logic                valid_next;
    mbc_pkg::mbc_state_t state_reg;
    mbc_pkg::mbc_state_t state_next;
    mbc_pkg::word_t      round_key;

    // One Feistel round; halves always swap, the top level undoes the last swap.
    always_comb begin
        round_key = keys[mbc_pkg::key_index(round_idx, in_state.decrypt)];
        state_next.decrypt = in_state.decrypt;
        state_next.hi      = in_state.lo;
        state_next.lo      = mbc_pkg::round_fn(round_key, in_state.lo) ^ in_state.hi;
        valid_next         = en ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            state_reg <= state_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

`default_nettype wire

/* rtl/mbc_out.sv */
`default_nettype none

module mbc_out (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    input  wire logic [63:0]              in_data,
    input  wire logic                     m_tready,
    output logic                          m_tvalid,
    output logic [63:0]                   m_tdata,
    output mbc_pkg::mbc_out_status_t      status
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] out_data_reg;
    logic [63:0] out_data_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    logic [63:0] skid_data_reg;
    logic [63:0] skid_data_next;
    logic        take;

    // An input item is taken only while the skid slot is empty.
    always_comb begin
        take            = in_valid && !skid_valid_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_valid_next = take;
            out_data_next  = in_data;
        end else if (take) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid         = out_valid_reg;
    assign m_tdata          = out_data_reg;
    assign status.skid_full = skid_valid_reg;

endmodule

`default_nettype wire

/* rtl/magma_block_cipher_top.sv */
// Throughput: one item per cycle while the skid slot is empty; each of the 32 Feistel
// rounds is its own register stage, followed by an output register with a one-entry skid slot.
// s_tready drops only while the skid slot holds an item; the pipeline then holds.
// Reset (aresetn low, synchronous) clears all valid bits and the key words to zero.
`default_nettype none

module magma_block_cipher_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Key word configuration.
    input  wire logic                          cfg_wr_en,
    input  wire logic [mbc_pkg::AddrWidth-1:0] cfg_addr,
    input  wire logic [31:0]                   cfg_wdata,
    // Input items.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [63:0]                   s_tdata,   // [63:0] block_in
    input  wire logic [0:0]                    s_tuser,   // [0] action
    // Result items.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [63:0]                        m_tdata    // [63:0] block_out
);

    mbc_pkg::key_bank_t       keys;
    mbc_pkg::mbc_out_status_t out_status;
    logic                     pipe_en;
    logic                     stage_valid [mbc_pkg::Rounds+1];
    mbc_pkg::mbc_state_t      stage_state [mbc_pkg::Rounds+1];
    logic [63:0]              result;

    mbc_keys u_keys (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .keys      (keys)
    );

    // The whole round pipeline advances together unless the skid slot is full.
    assign pipe_en  = !out_status.skid_full;
    assign s_tready = pipe_en;

    assign stage_valid[0]         = s_tvalid;
    assign stage_state[0].decrypt = (s_tuser[0] == mbc_pkg::ActDecrypt);
    assign stage_state[0].hi      = s_tdata[63:32];
    assign stage_state[0].lo      = s_tdata[31:0];

    for (genvar g = 0; g < mbc_pkg::Rounds; g++) begin : g_round
        mbc_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .round_idx (mbc_pkg::RoundIdxW'(g)),
            .keys      (keys),
            .in_valid  (stage_valid[g]),
            .in_state  (stage_state[g]),
            .out_valid (stage_valid[g+1]),
            .out_state (stage_state[g+1])
        );
    end

    // The last round swaps like every other, so put the halves back in place.
    assign result = {stage_state[mbc_pkg::Rounds].lo, stage_state[mbc_pkg::Rounds].hi};

    mbc_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (stage_valid[mbc_pkg::Rounds]),
        .in_data  (result),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .status   (out_status)
    );

    // The skid slot only holds an item while the output register holds one too.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        out_status.skid_full |-> m_tvalid)
        else $error("skid slot full while output register empty");

    // The skid slot fills only when a result was stalled at the output.
    a_skid_fill_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_status.skid_full) |-> $past(m_tvalid && !m_tready))
        else $error("skid slot filled without an output stall");

    // A full skid slot drains as soon as the output item is taken.
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        out_status.skid_full && m_tready |=> !out_status.skid_full && m_tvalid)
        else $error("skid slot did not drain after output handshake");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result pending after reset");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbc_pkg::*;

    // Key register map: key_word_i sits at RegKeyWord0 + i; the rest of the
    // address space is unused and writes there must be dropped.
    localparam logic [AddrWidth-1:0] RegKeyWord0    = '0;
    localparam logic [AddrWidth-1:0] RegKeyWordLast = RegKeyWord0 + AddrWidth'(KeyWords - 1);

    localparam int unsigned WatchdogLimit = 2000;
    localparam int unsigned DrainCycles   = 40;
    localparam int unsigned LongHold      = 200;
    localparam int unsigned MaxPrinted    = 20;
    localparam int unsigned ForwardRounds = 24;
    localparam int unsigned PhaseItems    = 120;
    localparam int unsigned BurstItems    = 60;

    // Substitution rows, row n for nibble n; entry 0 in the lowest nibble.
    localparam bit [7:0][63:0] SboxRows = {
        64'h2BC96AF4_3850DE71,
        64'h73AD0B4F_C19652E8,
        64'h0E34187B_AC296FD5,
        64'hC24BE390_D618A5F7,
        64'hB9E35A07_6F4D128C,
        64'h069C471E_DAF2853B,
        64'hF0DB74E1_C5A93286,
        64'h1F307D8E_9B5A264C
    };

    // Published test vector; key word 0 is the top 32 bits.
    localparam logic [255:0] StandardKey =
        256'hffeeddccbbaa99887766554433221100_f0f1f2f3f4f5f6f7f8f9fafbfcfdfeff;
    localparam logic [63:0] StandardPlain  = 64'hfedcba98_76543210;
    localparam logic [63:0] StandardCipher = 64'h4ee901e5_c2d8ca3d;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [AddrWidth-1:0] cfg_addr  = '0;
    logic [31:0]          cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [63:0]          m_tdata;

    key_bank_t     key_copy = '0;
    logic [63:0]   pending_blocks[$];
    logic [63:0]   oldest_block;
    int unsigned   error_count     = 0;
    int unsigned   quiet_cycles    = 0;
    int unsigned   sender_idle_pct = 0;
    int unsigned   recv_stall_pct  = 0;
    int unsigned   hold_cycles     = 0;

    magma_block_cipher_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [63:0] block_in
        .s_tuser   (s_tuser),    // [0] action
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)     // [63:0] block_out
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // One Feistel mix: key add mod 2^32, nibble substitution, rotate left by 11.
    function automatic word_t feistel_mix(input word_t rk, input word_t half);
        word_t sum;
        word_t sub;
        int    nib;
        sum = rk + half;
        for (int n = 0; n < 8; n++) begin
            nib = int'(sum[4*n +: 4]);
            sub[4*n +: 4] = SboxRows[n][4*nib +: 4];
        end
        return {sub[20:0], sub[31:21]};
    endfunction

    // Expected cipher output for one block under the given key bank.
    function automatic logic [63:0] predict_block(input logic decrypt, input logic [63:0] blk,
                                                 input key_bank_t keys);
        word_t       hi;
        word_t       lo;
        word_t       mixed;
        int unsigned sched;
        int unsigned widx;
        hi = blk[63:32];
        lo = blk[31:0];
        for (int r = 0; r < Rounds; r++) begin
            // Decryption walks the encryption schedule from the far end.
            sched = decrypt ? (Rounds - 1 - r) : r;
            widx  = (sched < ForwardRounds) ? (sched % KeyWords) : (Rounds - 1 - sched);
            mixed = feistel_mix(keys[KeyIdxW'(widx)], lo) ^ hi;
            if (r == Rounds - 1) begin
                hi = mixed;
            end else begin
                hi = lo;
                lo = mixed;
            end
        end
        return {hi, lo};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < MaxPrinted) begin
            $display("mismatch: %s: got %h, expected %h", what, got, want);
        end
        error_count++;
    endtask

    // Tracks key writes, predicts every accepted item and checks every result.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en && cfg_addr <= RegKeyWordLast) begin
                key_copy[KeyIdxW'(cfg_addr - RegKeyWord0)] = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                pending_blocks.push_back(predict_block(s_tuser[0], s_tdata, key_copy));
            end
            if (m_tvalid && m_tready) begin
                if (pending_blocks.size() == 0) begin
                    report_mismatch("result with no item pending", m_tdata, 'x);
                end else begin
                    oldest_block = pending_blocks.pop_front();
                    if (m_tdata !== oldest_block) begin
                        report_mismatch("block_out", m_tdata, oldest_block);
                    end
                end
            end
        end
    end

    // Ends the run when no item moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WatchdogLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: a requested long hold-off first, otherwise random stalls.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [AddrWidth-1:0] addr, input logic [31:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Key word 0 comes from the top 32 bits of the 256-bit key.
    task automatic load_key(input logic [255:0] key);
        for (int i = 0; i < KeyWords; i++) begin
            write_reg(RegKeyWord0 + AddrWidth'(i), key[255 - 32*i -: 32]);
        end
        end_writes();
    endtask

    task automatic load_random_key();
        logic [255:0] key;
        for (int i = 0; i < 8; i++) begin
            key[32*i +: 32] = $urandom;
        end
        load_key(key);
    endtask

    // Offers one item, idling first at the current rate, and waits for acceptance.
    task automatic send_block(input logic decrypt, input logic [63:0] blk);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            s_tuser  <= 1'($urandom);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        s_tuser  <= decrypt;
        do begin
            @(posedge aclk);
        end while (s_tready !== 1'b1);
    endtask

    task automatic send_random_blocks(input int unsigned count);
        repeat (count) begin
            send_block(1'($urandom), {$urandom, $urandom});
        end
    endtask

    // Stops offering items and waits until every result has come back.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_blocks.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Key words are all zero straight out of reset.
    task automatic test_reset_key();
        send_block(ActEncrypt, 64'h0);
        send_block(ActDecrypt, '1);
        send_block(ActEncrypt, '1);
        send_block(ActDecrypt, 64'h0);
        wait_drained();
    endtask

    // The published vector, in both directions.
    task automatic test_known_answer();
        load_key(StandardKey);
        if (predict_block(ActEncrypt, StandardPlain, key_copy) !== StandardCipher) begin
            report_mismatch("predictor on the standard vector",
                            predict_block(ActEncrypt, StandardPlain, key_copy), StandardCipher);
        end
        send_block(ActEncrypt, StandardPlain);
        send_block(ActDecrypt, StandardCipher);
        wait_drained();
    endtask

    // All-ones keys force the key add to wrap; alternating bits toggle every nibble.
    task automatic test_extreme_keys();
        load_key('1);
        send_block(ActEncrypt, 64'h0);
        send_block(ActDecrypt, '1);
        send_block(ActEncrypt, 64'h1);
        send_block(ActDecrypt, 64'h8000_0000_0000_0000);
        send_block(ActEncrypt, 64'h5555_5555_5555_5555);
        send_block(ActDecrypt, 64'haaaa_aaaa_aaaa_aaaa);
        wait_drained();
        load_key({8{32'haaaa_5555}});
        send_block(ActEncrypt, 64'h0000_0001_ffff_ffff);
        send_block(ActDecrypt, 64'hffff_ffff_0000_0001);
        send_block(ActEncrypt, 64'h8000_0000_7fff_ffff);
        send_block(ActDecrypt, '1);
        wait_drained();
    endtask

    // Writes to the unused register addresses must leave the key untouched.
    task automatic test_unused_addresses();
        load_random_key();
        for (int a = int'(RegKeyWordLast) + 1; a < 2**AddrWidth; a++) begin
            write_reg(AddrWidth'(a), $urandom);
        end
        end_writes();
        send_block(ActEncrypt, {$urandom, $urandom});
        send_block(ActDecrypt, {$urandom, $urandom});
        wait_drained();
    endtask

    // Random items under each idling pattern, each with a fresh key.
    task automatic test_random_phases();
        int unsigned idle_pct[4];
        int unsigned stall_pct[4];
        idle_pct  = '{0, 67, 0, 38};
        stall_pct = '{0, 0, 67, 38};
        for (int p = 0; p < 4; p++) begin
            load_random_key();
            sender_idle_pct = idle_pct[p];
            recv_stall_pct  = stall_pct[p];
            send_random_blocks(PhaseItems);
            wait_drained();
        end
    endtask

    // The result side holds off long enough for the pipeline to fill and stall input.
    task automatic test_backpressure();
        load_random_key();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_cycles     = LongHold;
        send_random_blocks(BurstItems);
        wait_drained();
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_key();
        test_known_answer();
        test_extreme_keys();
        test_unused_addresses();
        test_random_phases();
        test_backpressure();

        // Let any stray result surface before the verdict.
        recv_stall_pct = 0;
        wait_drained();
        repeat (DrainCycles) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
